// ===== rtl/core/tsa_pkg.sv =====
// tsa_pkg: shared types, codes and defaults for the tagged slot allocator
// used by tsa_cell and tagged_slot_allocator_unit; no dependencies
package tsa_pkg;

  localparam int TSA_SLOTS       = 16;
  localparam int TSA_LAYER_BITS  = 8;
  localparam int TSA_EXPERT_BITS = 8;

  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_LOOKUP  = 2'd2,
    OP_COUNT   = 2'd3
  } tsa_op_e_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_EPOCH = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_RANGE     = 3'd5
  } tsa_status_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  layer;
    logic [7:0]  expert;
    logic [63:0] epoch;
    logic [5:0]  slot_in;
  } tsa_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] slot_out;
    logic [6:0] used_count;
  } tsa_out_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic       cmp_en;
    logic       acq_go;
    logic       rel_go;
    logic [5:0] rel_slot;
  } tsa_ctl_t;

  // passed from cell to cell along the row
  typedef struct packed {
    logic       any_free;
    logic       any_hit;
    logic [5:0] free_idx;
    logic [5:0] hit_idx;
  } tsa_link_t;

endpackage

// ===== rtl/core/tsa_cell.sv =====
// tsa_cell: one slot of the allocator row, holding busy flag and tag
// depends on tsa_pkg for the control and link structs
module tsa_cell import tsa_pkg::*; #(
  parameter int LAYER_BITS  = TSA_LAYER_BITS,
  parameter int EXPERT_BITS = TSA_EXPERT_BITS,
  parameter int IDX         = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tsa_ctl_t               ctl,
  input  logic [LAYER_BITS-1:0]  key_layer,
  input  logic [EXPERT_BITS-1:0] key_expert,
  input  logic [63:0]            key_epoch,
  input  tsa_link_t              link_in,
  output tsa_link_t              link_out,
  output logic                   hit,
  output logic                   busy
);

  localparam logic [5:0] MY_IDX = 6'(IDX);

  logic [LAYER_BITS-1:0]  tag_layer;
  logic [EXPERT_BITS-1:0] tag_expert;
  logic [63:0]            tag_epoch;
  logic                   first_free;
  logic                   tag_eq;

  assign first_free = !busy && !link_in.any_free;
  assign tag_eq = (tag_layer == key_layer) && (tag_expert == key_expert) &&
                  (tag_epoch == key_epoch);

  always_comb begin
    link_out.any_free = link_in.any_free || !busy;
    link_out.free_idx = first_free ? MY_IDX : link_in.free_idx;
    link_out.any_hit  = link_in.any_hit || hit;
    // tags are unique among busy slots, so at most one cell ors in its index
    link_out.hit_idx  = link_in.hit_idx | (hit ? MY_IDX : 6'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      hit  <= 1'b0;
    end else begin
      if (ctl.acq_go && first_free) begin
        busy <= 1'b1;
      end else if (ctl.rel_go && ctl.rel_slot == MY_IDX) begin
        busy <= 1'b0;
      end
      if (ctl.cmp_en) begin
        hit <= busy && tag_eq;
      end
    end
  end

  // a free slot never matches, so the tag needs no clearing on release
  always_ff @(posedge clk) begin
    if (ctl.acq_go && first_free) begin
      tag_layer  <= key_layer;
      tag_expert <= key_expert;
      tag_epoch  <= key_epoch;
    end
  end

endmodule

// ===== rtl/core/tagged_slot_allocator_unit.sv =====
// tagged_slot_allocator_unit: row of SLOTS tsa_cell instances plus sequencer
// an accepted item passes the compare state, then write-back, which stalls until
// the output can load; the next item is taken in the write-back cycle
// as the result loads; the free/hit chain through the cell row is combinational
// synchronous active-high reset frees every slot and clears default_layer
module tagged_slot_allocator_unit import tsa_pkg::*; #(
  parameter int SLOTS       = TSA_SLOTS,
  parameter int LAYER_BITS  = TSA_LAYER_BITS,
  parameter int EXPERT_BITS = TSA_EXPERT_BITS
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic     in_valid,
  output logic     in_ready,
  input  tsa_in_t  in_item,
  output logic     out_valid,
  input  logic     out_ready,
  output tsa_out_t out_item
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_WB   = 3'b100
  } state_t;

  state_t state, state_next;

  logic [LAYER_BITS-1:0]  default_layer;
  tsa_op_e_t              op_q;
  logic [LAYER_BITS-1:0]  layer_q;
  logic [EXPERT_BITS-1:0] expert_q;
  logic [63:0]            epoch_q;
  logic [5:0]             slot_q;
  logic [6:0]             used_cnt, used_cnt_next;

  tsa_ctl_t               ctl;
  tsa_link_t              link [SLOTS+1];
  logic [SLOTS-1:0]       hit_vec;
  logic [SLOTS-1:0]       busy_vec;
  logic [LAYER_BITS-1:0]  key_layer;

  logic        in_acc;
  logic        out_can_load;
  logic        wb_fire;
  logic        rel_in_range;
  logic        rel_hit;
  tsa_status_t status;
  logic [5:0]  slot_res;

  assign out_can_load = !out_valid || out_ready;
  assign wb_fire      = (state == S_WB) && out_can_load;
  assign in_ready     = (state == S_IDLE) || wb_fire;
  assign in_acc       = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_layer <= '0;
    end else if (cfg_wr_en) begin
      default_layer <= LAYER_BITS'(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_q     <= tsa_op_e_t'(in_item.op);
      layer_q  <= LAYER_BITS'(in_item.layer);
      expert_q <= EXPERT_BITS'(in_item.expert);
      epoch_q  <= in_item.epoch;
      slot_q   <= in_item.slot_in;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_acc) state_next = S_CMP;
      S_CMP:  state_next = S_WB;
      S_WB: begin
        if (wb_fire) state_next = in_acc ? S_CMP : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // lookup matches against the configured layer
  assign key_layer = (op_q == OP_LOOKUP) ? default_layer : layer_q;

  assign link[0] = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    tsa_cell #(
      .LAYER_BITS  (LAYER_BITS),
      .EXPERT_BITS (EXPERT_BITS),
      .IDX         (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .key_layer  (key_layer),
      .key_expert (expert_q),
      .key_epoch  (epoch_q),
      .link_in    (link[i]),
      .link_out   (link[i+1]),
      .hit        (hit_vec[i]),
      .busy       (busy_vec[i])
    );
  end

  assign rel_in_range = {1'b0, slot_q} < 7'(SLOTS);
  assign rel_hit = rel_in_range ? hit_vec[slot_q[SLOT_W-1:0]] : 1'b0;

  always_comb begin
    status        = ST_OK;
    slot_res      = 6'd0;
    ctl.cmp_en    = (state == S_CMP);
    ctl.acq_go    = 1'b0;
    ctl.rel_go    = 1'b0;
    ctl.rel_slot  = slot_q;
    used_cnt_next = used_cnt;
    case (op_q)
      OP_ACQUIRE: begin
        if (epoch_q == 64'd0) begin
          status = ST_BAD_EPOCH;
        end else if (link[SLOTS].any_hit) begin
          status = ST_DUPLICATE;
        end else if (!link[SLOTS].any_free) begin
          status = ST_FULL;
        end else begin
          slot_res      = link[SLOTS].free_idx;
          ctl.acq_go    = wb_fire;
          used_cnt_next = used_cnt + 7'd1;
        end
      end
      OP_RELEASE: begin
        if (!rel_in_range) begin
          status = ST_RANGE;
        end else if (!rel_hit) begin
          status = ST_NOT_FOUND;
        end else begin
          slot_res      = slot_q;
          ctl.rel_go    = wb_fire;
          used_cnt_next = used_cnt - 7'd1;
        end
      end
      OP_LOOKUP: begin
        if (link[SLOTS].any_hit) slot_res = link[SLOTS].hit_idx;
        else                     status   = ST_NOT_FOUND;
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_cnt  <= 7'd0;
      out_valid <= 1'b0;
    end else begin
      if (wb_fire) begin
        used_cnt  <= used_cnt_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wb_fire) begin
      out_item.status     <= status;
      out_item.slot_out   <= slot_res;
      out_item.used_count <= used_cnt_next;
    end
  end

`ifndef SYNTHESIS
  a_count_matches_busy: assert property (@(posedge clk) disable iff (rst)
    $countones(busy_vec) == 32'(used_cnt))
    else $error("used count disagrees with busy slots");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    used_cnt <= 7'(SLOTS))
    else $error("used count above slot count");

  a_unique_hit: assert property (@(posedge clk) disable iff (rst)
    state == S_WB |-> $onehot0(hit_vec))
    else $error("tag held by more than one slot");

  a_accept_to_cmp: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_CMP)
    else $error("accepted item did not enter compare");
`endif

endmodule
